// File: sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table core.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  // default geometry
  localparam int TABLE_SIZE_DEF = 16;
  localparam int KEY_BITS_DEF   = 64;

  // fixed field widths
  localparam int HOME_BITS   = 4;
  localparam int KEY_IN_BITS = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_DONE   = 2'd1,
    ST_OTHER_HOME = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;     // capture input item
    logic    reduce;   // subtract table size from home slot
    logic    start;    // point probe at home slot
    logic    advance;  // step probe to next slot
    logic    wr_en;    // write table entry at probe slot
    logic    wr_fill;  // write key and home (else zero)
    logic    code_set; // latch result code
    status_t code;
    logic    out_load; // move result code to output register
    logic    probing;  // comparing a read slot
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic trivial;    // zero key or unknown command
    logic home_big;   // home slot not yet below table size
    logic match;      // read slot holds the key
    logic empty;      // read slot is empty
    logic count_last; // last slot of the ring
    logic slot_last;  // probe pointer at highest slot
    logic home_ok;    // first probe or recorded home equal
    cmd_t cmd;
    logic out_busy;   // output register holds an untaken result
  } sts_t;

endpackage

`default_nettype wire

// File: sv/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/lpht_datapath.sv
// ----------------------------------------------------------------------------
// lpht_datapath
// Item registers, probe pointer, slot table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_datapath #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [1:0]                        cmd,
  input  wire logic [lpht_pkg::KEY_IN_BITS-1:0]  key,
  input  wire logic [lpht_pkg::HOME_BITS-1:0]    home_slot,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic      [1:0]                        status,
  input  wire lpht_pkg::ctl_t                    ctl,
  output lpht_pkg::sts_t                         sts
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int ENT_W  = KEY_BITS + SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [lpht_pkg::HOME_BITS-1:0] SIZE_LOW = lpht_pkg::HOME_BITS'(TABLE_SIZE);

  lpht_pkg::cmd_t                   cmd_r;
  logic [KEY_BITS-1:0]              key_r;
  logic [lpht_pkg::HOME_BITS-1:0]   home_r;
  logic [SLOT_W-1:0]                slot;
  logic [SLOT_W-1:0]                slot_next;
  logic [SLOT_W-1:0]                count;
  logic [SLOT_W-1:0]                home_idx;
  lpht_pkg::status_t                code;
  logic [SLOT_W-1:0]                raddr;
  logic [ENT_W-1:0]                 wdata;
  logic [ENT_W-1:0]                 rdata;
  logic [KEY_BITS-1:0]              rd_key;
  logic [SLOT_W-1:0]                rd_home;

  assign home_idx  = SLOT_W'(home_r);
  assign slot_next = (slot == SLOT_MAX) ? '0 : slot + 1'b1;

  // item capture and home slot reduction
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= lpht_pkg::cmd_t'(cmd);
      key_r  <= key[KEY_BITS-1:0];
      home_r <= home_slot;
    end else if (ctl.reduce) begin
      home_r <= home_r - SIZE_LOW;
    end
  end

  // probe pointer, also sweeps the table after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
    end else if (ctl.start) begin
      slot  <= home_idx;
      count <= '0;
    end else if (ctl.advance) begin
      slot  <= slot_next;
      count <= count + 1'b1;
    end
  end

  // slot table, entry is recorded home over key
  assign raddr = ctl.advance ? slot_next : slot;
  assign wdata = ctl.wr_fill ? {home_idx, key_r} : '0;

  lpht_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.wr_en),
    .waddr(slot),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_key  = rdata[KEY_BITS-1:0];
  assign rd_home = rdata[KEY_BITS +: SLOT_W];

  // result code and output register
  always_ff @(posedge clk) begin
    if (ctl.code_set) begin
      code <= ctl.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status <= code;
    end
  end

  // status toward the controller
  always_comb begin
    sts.trivial    = (key_r == '0) ||
                     !(cmd_r == lpht_pkg::CMD_INSERT || cmd_r == lpht_pkg::CMD_SEARCH ||
                       cmd_r == lpht_pkg::CMD_DELETE);
    sts.home_big   = (32'(home_r) >= 32'(TABLE_SIZE));
    sts.match      = (rd_key == key_r);
    sts.empty      = (rd_key == '0);
    sts.count_last = (count == SLOT_MAX);
    sts.slot_last  = (slot == SLOT_MAX);
    sts.home_ok    = (count == '0) || (rd_home == home_idx);
    sts.cmd        = cmd_r;
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// File: sv/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer for table clear, home reduction, probing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lpht_pkg::sts_t sts,
  output lpht_pkg::ctl_t      ctl
);

  lpht_pkg::state_t state;
  lpht_pkg::state_t state_next;
  logic             probe_done;

  // probe ends on a match, a free slot for insert, or a full ring
  assign probe_done = sts.match || sts.count_last ||
                      (sts.cmd == lpht_pkg::CMD_INSERT && sts.empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpht_pkg::S_CLEAR: begin
        if (sts.slot_last) state_next = lpht_pkg::S_IDLE;
      end
      lpht_pkg::S_IDLE: begin
        if (in_valid) state_next = lpht_pkg::S_REDUCE;
      end
      lpht_pkg::S_REDUCE: begin
        priority if (sts.trivial) state_next = lpht_pkg::S_FINISH;
        else if (sts.home_big)   state_next = lpht_pkg::S_REDUCE;
        else                     state_next = lpht_pkg::S_READ;
      end
      lpht_pkg::S_READ: begin
        state_next = lpht_pkg::S_CHECK;
      end
      lpht_pkg::S_CHECK: begin
        if (probe_done) state_next = lpht_pkg::S_FINISH;
      end
      lpht_pkg::S_FINISH: begin
        if (!sts.out_busy) state_next = lpht_pkg::S_IDLE;
      end
      default: state_next = lpht_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    ctl      = '0;
    ctl.code = lpht_pkg::ST_NOT_DONE;
    in_ready = 1'b0;
    unique case (state)
      lpht_pkg::S_CLEAR: begin
        ctl.wr_en   = 1'b1;
        ctl.advance = 1'b1;
      end
      lpht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      lpht_pkg::S_REDUCE: begin
        priority if (sts.trivial) ctl.code_set = 1'b1;
        else if (sts.home_big)   ctl.reduce   = 1'b1;
        else                     ctl.start    = 1'b1;
      end
      lpht_pkg::S_READ: begin
      end
      lpht_pkg::S_CHECK: begin
        ctl.probing = 1'b1;
        unique case (sts.cmd)
          lpht_pkg::CMD_INSERT: begin
            priority if (sts.match) begin
              ctl.code_set = 1'b1;
            end else if (sts.empty) begin
              ctl.wr_en    = 1'b1;
              ctl.wr_fill  = 1'b1;
              ctl.code_set = 1'b1;
              ctl.code     = lpht_pkg::ST_OK;
            end else if (sts.count_last) begin
              ctl.code_set = 1'b1;
            end else begin
              ctl.advance = 1'b1;
            end
          end
          lpht_pkg::CMD_SEARCH: begin
            priority if (sts.match) begin
              ctl.code_set = 1'b1;
              ctl.code     = sts.home_ok ? lpht_pkg::ST_OK : lpht_pkg::ST_OTHER_HOME;
            end else if (sts.count_last) begin
              ctl.code_set = 1'b1;
            end else begin
              ctl.advance = 1'b1;
            end
          end
          lpht_pkg::CMD_DELETE: begin
            priority if (sts.match) begin
              ctl.wr_en    = 1'b1;
              ctl.code_set = 1'b1;
              ctl.code     = lpht_pkg::ST_OK;
            end else if (sts.count_last) begin
              ctl.code_set = 1'b1;
            end else begin
              ctl.advance = 1'b1;
            end
          end
          default: begin
            ctl.code_set = 1'b1;
          end
        endcase
      end
      lpht_pkg::S_FINISH: begin
        ctl.out_load = !sts.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing hash table with linear probing; caller gives the home slot.
// ----------------------------------------------------------------------------
// Flow: a zero key or unknown command skips the probe and goes straight to the result;
//   otherwise TABLE_SIZE is subtracted from home_slot, one step at a time, before the probe.
// One item is taken at a time, and a new result waits while the last one waits on
//   out_ready; the probe reads one slot per cycle through the single read port.
// Reset: a clear pass writes every slot empty, with in_ready low until it ends.
`default_nettype none

module linear_probe_hash_table_core #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       cmd,
  input  wire logic [lpht_pkg::KEY_IN_BITS-1:0] key,
  input  wire logic [lpht_pkg::HOME_BITS-1:0]   home_slot,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [1:0]                       status
);

  lpht_pkg::ctl_t ctl;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  lpht_datapath #(
    .TABLE_SIZE(TABLE_SIZE),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .key      (key),
    .home_slot(home_slot),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .status   (status),
    .ctl      (ctl),
    .sts      (sts)
  );

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a nonzero key cannot both match and look empty
  a_match_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.probing |-> !(sts.match && sts.empty))
    else $error("probe saw match and empty together");

  // a new result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

endmodule

`default_nettype wire
